// ----- hw/rtl/hsvrgb_pkg.sv -----
`timescale 1ns / 1ps

package hsvrgb_pkg;

   // Field width of every color component on the ports
   localparam int FIELD_W = 16;

   // Default fraction width of the internal fixed-point format
   localparam int FRAC_BITS_DEFAULT = 16;

   // Hue sectors, integer part of hue * 6
   localparam int SECTOR_W = 3;
   localparam logic [SECTOR_W-1:0] SECTOR_RED     = 3'd0;
   localparam logic [SECTOR_W-1:0] SECTOR_YELLOW  = 3'd1;
   localparam logic [SECTOR_W-1:0] SECTOR_GREEN   = 3'd2;
   localparam logic [SECTOR_W-1:0] SECTOR_CYAN    = 3'd3;
   localparam logic [SECTOR_W-1:0] SECTOR_BLUE    = 3'd4;
   localparam logic [SECTOR_W-1:0] SECTOR_MAGENTA = 3'd5;

   typedef struct packed {
      logic [FIELD_W-1:0] hue;
      logic [FIELD_W-1:0] saturation;
      logic [FIELD_W-1:0] brightness;
   } req_word_type;

   typedef struct packed {
      logic [FIELD_W-1:0] red;
      logic [FIELD_W-1:0] green;
      logic [FIELD_W-1:0] blue;
   } rsp_word_type;

   // Load enables for the two product stages
   typedef struct packed {
      logic load2;
      logic load3;
   } prod_ctrl_type;

endpackage

// ----- hw/rtl/hsvrgb_sector_split.sv -----
`timescale 1ns / 1ps

module hsvrgb_sector_split import hsvrgb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 load,
   input  req_word_type         in_word,
   output logic                 valid_ff,
   output logic [SECTOR_W-1:0]  sector_ff,
   output logic [FRAC_BITS-1:0] frac_ff,
   output logic [FRAC_BITS:0]   frac_inv_ff,
   output logic [FRAC_BITS-1:0] sat_ff,
   output logic [FRAC_BITS:0]   sat_inv_ff,
   output logic [FRAC_BITS-1:0] val_ff
);

   localparam int FB = FRAC_BITS;
   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

   logic [FB-1:0]       hue_m;
   logic [FB+2:0]       hue6;
   logic [SECTOR_W-1:0] sector_in;
   logic [FB-1:0]       frac_in;
   logic [FB:0]         frac_inv_in;
   logic [FB-1:0]       sat_in;
   logic [FB:0]         sat_inv_in;
   logic [FB-1:0]       val_in;

   // Mask fields to the fraction width, split hue * 6 into sector and fraction
   always_comb begin
      hue_m       = FB'(in_word.hue);
      sat_in      = FB'(in_word.saturation);
      val_in      = FB'(in_word.brightness);
      hue6        = ({3'b000, hue_m} << 2) + ({3'b000, hue_m} << 1);
      sector_in   = hue6[FB+2:FB];
      frac_in     = hue6[FB-1:0];
      frac_inv_in = ONE - {1'b0, frac_in};
      sat_inv_in  = ONE - {1'b0, sat_in};
   end

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Hold the payload unless a new word loads
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         sector_ff   <= sector_in;
         frac_ff     <= frac_in;
         frac_inv_ff <= frac_inv_in;
         sat_ff      <= sat_in;
         sat_inv_ff  <= sat_inv_in;
         val_ff      <= val_in;
      end
   end

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (sector_ff <= SECTOR_MAGENTA) && (frac_inv_ff + {1'b0, frac_ff} == ONE))
      else $error("sector out of range or fraction split broken");

endmodule

// ----- hw/rtl/hsvrgb_products.sv -----
`timescale 1ns / 1ps

module hsvrgb_products import hsvrgb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  prod_ctrl_type        ctrl,
   input  logic                 s1_valid,
   input  logic [SECTOR_W-1:0]  s1_sector,
   input  logic [FRAC_BITS-1:0] s1_frac,
   input  logic [FRAC_BITS:0]   s1_frac_inv,
   input  logic [FRAC_BITS-1:0] s1_sat,
   input  logic [FRAC_BITS:0]   s1_sat_inv,
   input  logic [FRAC_BITS-1:0] s1_val,
   output logic                 s2_valid_ff,
   output logic                 s3_valid_ff,
   output logic [SECTOR_W-1:0]  s3_sector_ff,
   output logic [FRAC_BITS-1:0] s3_val_ff,
   output logic [FRAC_BITS-1:0] s3_p_ff,
   output logic [FRAC_BITS-1:0] s3_q_ff,
   output logic [FRAC_BITS-1:0] s3_t_ff
);

   localparam int FB = FRAC_BITS;
   localparam int PW = 2 * FB + 1;
   localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

   logic [PW-1:0]       fs_prod;
   logic [PW-1:0]       gs_prod;
   logic [PW-1:0]       p_prod;
   logic [FB-1:0]       fs_in;
   logic [FB-1:0]       gs_in;
   logic [FB-1:0]       p_in;

   logic [SECTOR_W-1:0] s2_sector_ff;
   logic [FB-1:0]       s2_val_ff;
   logic [FB-1:0]       s2_p_ff;
   logic [FB-1:0]       s2_fs_ff;
   logic [FB-1:0]       s2_gs_ff;

   logic [FB:0]         fs_inv;
   logic [FB:0]         gs_inv;
   logic [PW-1:0]       q_prod;
   logic [PW-1:0]       t_prod;
   logic [FB-1:0]       q_in;
   logic [FB-1:0]       t_in;

   // Stage 2: f*s, (1-f)*s and p = v*(1-s), each truncated
   always_comb begin
      fs_prod = PW'(s1_frac) * PW'(s1_sat);
      gs_prod = PW'(s1_frac_inv) * PW'(s1_sat);
      p_prod  = PW'(s1_val) * PW'(s1_sat_inv);
      fs_in   = fs_prod[2*FB-1:FB];
      gs_in   = gs_prod[2*FB-1:FB];
      p_in    = p_prod[2*FB-1:FB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ctrl.load2) begin
         s2_valid_ff <= s1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load2 && s1_valid) begin
         s2_sector_ff <= s1_sector;
         s2_val_ff    <= s1_val;
         s2_p_ff      <= p_in;
         s2_fs_ff     <= fs_in;
         s2_gs_ff     <= gs_in;
      end
   end

   // Stage 3: q = v*(1-f*s) and t = v*(1-(1-f)*s)
   always_comb begin
      fs_inv = ONE - {1'b0, s2_fs_ff};
      gs_inv = ONE - {1'b0, s2_gs_ff};
      q_prod = PW'(s2_val_ff) * PW'(fs_inv);
      t_prod = PW'(s2_val_ff) * PW'(gs_inv);
      q_in   = q_prod[2*FB-1:FB];
      t_in   = t_prod[2*FB-1:FB];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ctrl.load3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load3 && s2_valid_ff) begin
         s3_sector_ff <= s2_sector_ff;
         s3_val_ff    <= s2_val_ff;
         s3_p_ff      <= s2_p_ff;
         s3_q_ff      <= q_in;
         s3_t_ff      <= t_in;
      end
   end

   a_below_value: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_p_ff <= s3_val_ff) && (s3_q_ff <= s3_val_ff)
                      && (s3_t_ff <= s3_val_ff))
      else $error("channel exceeds brightness");

endmodule

// ----- hw/rtl/hsvrgb_route.sv -----
`timescale 1ns / 1ps

module hsvrgb_route import hsvrgb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  logic                 load,
   input  logic [SECTOR_W-1:0]  sector,
   input  logic [FRAC_BITS-1:0] val,
   input  logic [FRAC_BITS-1:0] p,
   input  logic [FRAC_BITS-1:0] q,
   input  logic [FRAC_BITS-1:0] t,
   output logic                 valid_ff,
   output rsp_word_type         word_ff
);

   logic [FRAC_BITS-1:0] r_sel;
   logic [FRAC_BITS-1:0] g_sel;
   logic [FRAC_BITS-1:0] b_sel;
   rsp_word_type         word_in;

   // Route v, p, q, t to the channels by sector
   always_comb begin
      unique case (sector)
         SECTOR_RED: begin
            r_sel = val; g_sel = t;   b_sel = p;
         end
         SECTOR_YELLOW: begin
            r_sel = q;   g_sel = val; b_sel = p;
         end
         SECTOR_GREEN: begin
            r_sel = p;   g_sel = val; b_sel = t;
         end
         SECTOR_CYAN: begin
            r_sel = p;   g_sel = q;   b_sel = val;
         end
         SECTOR_BLUE: begin
            r_sel = t;   g_sel = p;   b_sel = val;
         end
         default: begin
            r_sel = val; g_sel = p;   b_sel = q;
         end
      endcase
      word_in.red   = FIELD_W'(r_sel);
      word_in.green = FIELD_W'(g_sel);
      word_in.blue  = FIELD_W'(b_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   // Hold the result word while stalled
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         word_ff <= word_in;
      end
   end

endmodule

// ----- hw/rtl/hsv_to_rgb_converter_core.sv -----
`timescale 1ns / 1ps

// HSV to RGB converter. Takes one color word per clock when nothing stalls and
// presents one RGB word per accepted input word. Hue, saturation and
// brightness are unsigned fractions of 2^FRAC_BITS; each product is
// truncated. Four register stages: sector split (hue*6), three parallel
// multipliers for f*s, (1-f)*s and p, two multipliers for q and t, then the
// sector routing into the output register. Every multiplier is fully
// pipelined, so the sustained rate is one word per cycle while the result side
// does not stall; a stall on the result side fills bubbles first and only then
// stalls the input.

module hsv_to_rgb_converter_core import hsvrgb_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int FB = FRAC_BITS;

   logic                s1_valid;
   logic [SECTOR_W-1:0] s1_sector;
   logic [FB-1:0]       s1_frac;
   logic [FB:0]         s1_frac_inv;
   logic [FB-1:0]       s1_sat;
   logic [FB:0]         s1_sat_inv;
   logic [FB-1:0]       s1_val;

   logic                s2_valid;
   logic                s3_valid;
   logic [SECTOR_W-1:0] s3_sector;
   logic [FB-1:0]       s3_val;
   logic [FB-1:0]       s3_p;
   logic [FB-1:0]       s3_q;
   logic [FB-1:0]       s3_t;

   logic                load_out;
   logic                load1;
   prod_ctrl_type       prod_ctrl;

   // A stage loads when it is empty or the stage after it moves on
   always_comb begin
      load_out        = !rsp_valid || !rsp_stall;
      prod_ctrl.load3 = !s3_valid || load_out;
      prod_ctrl.load2 = !s2_valid || prod_ctrl.load3;
      load1           = !s1_valid || prod_ctrl.load2;
      req_stall       = !load1;
   end

   hsvrgb_sector_split #(
      .FRAC_BITS (FRAC_BITS)
   ) u_split (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .load        (load1),
      .in_word     (req_word),
      .valid_ff    (s1_valid),
      .sector_ff   (s1_sector),
      .frac_ff     (s1_frac),
      .frac_inv_ff (s1_frac_inv),
      .sat_ff      (s1_sat),
      .sat_inv_ff  (s1_sat_inv),
      .val_ff      (s1_val)
   );

   hsvrgb_products #(
      .FRAC_BITS (FRAC_BITS)
   ) u_products (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (prod_ctrl),
      .s1_valid     (s1_valid),
      .s1_sector    (s1_sector),
      .s1_frac      (s1_frac),
      .s1_frac_inv  (s1_frac_inv),
      .s1_sat       (s1_sat),
      .s1_sat_inv   (s1_sat_inv),
      .s1_val       (s1_val),
      .s2_valid_ff  (s2_valid),
      .s3_valid_ff  (s3_valid),
      .s3_sector_ff (s3_sector),
      .s3_val_ff    (s3_val),
      .s3_p_ff      (s3_p),
      .s3_q_ff      (s3_q),
      .s3_t_ff      (s3_t)
   );

   hsvrgb_route #(
      .FRAC_BITS (FRAC_BITS)
   ) u_route (
      .clock    (clock),
      .reset    (reset),
      .in_valid (s3_valid),
      .load     (load_out),
      .sector   (s3_sector),
      .val      (s3_val),
      .p        (s3_p),
      .q        (s3_q),
      .t        (s3_t),
      .valid_ff (rsp_valid),
      .word_ff  (rsp_word)
   );

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid && s2_valid && s3_valid && rsp_valid)
      else $error("input stalled with a bubble in the pipeline");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid && !prod_ctrl.load2 |=> s1_valid && $stable(s1_sector) && $stable(s1_val))
      else $error("stage 1 word dropped or changed while held");

   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      s3_valid && !load_out |=> s3_valid && $stable(s3_q) && $stable(s3_t))
      else $error("stage 3 word dropped or changed while held");

endmodule

// ----- sim/hsv_rgb_checker.sv -----
`timescale 1ns / 1ps

module hsv_rgb_checker import hsvrgb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   output int           fail_count,
   output int           pending
);

   localparam int          FB       = FRAC_BITS_DEFAULT;
   localparam logic [63:0] UNITY    = 64'd1 << FB;
   localparam logic [63:0] FRAC_MSK = UNITY - 64'd1;

   rsp_word_type rgb_expected[$];
   int           rsp_index;

   initial begin
      fail_count = 0;
      pending    = 0;
      rsp_index  = 0;
   end

   // Convert one HSV word to the RGB word the block must return
   function automatic rsp_word_type predict_rgb(req_word_type color);
      logic [63:0]         h, s, v, h6, f, p, q, t, r, g, b;
      logic [SECTOR_W-1:0] sector;
      rsp_word_type        rgb;
      h      = 64'(color.hue) & FRAC_MSK;
      s      = 64'(color.saturation) & FRAC_MSK;
      v      = 64'(color.brightness) & FRAC_MSK;
      h6     = h * 64'd6;
      sector = SECTOR_W'(h6 >> FB);
      f      = h6 & FRAC_MSK;
      p      = (v * (UNITY - s)) >> FB;
      q      = (v * (UNITY - ((f * s) >> FB))) >> FB;
      t      = (v * (UNITY - (((UNITY - f) * s) >> FB))) >> FB;
      case (sector)
         SECTOR_RED: begin
            r = v; g = t; b = p;
         end
         SECTOR_YELLOW: begin
            r = q; g = v; b = p;
         end
         SECTOR_GREEN: begin
            r = p; g = v; b = t;
         end
         SECTOR_CYAN: begin
            r = p; g = q; b = v;
         end
         SECTOR_BLUE: begin
            r = t; g = p; b = v;
         end
         default: begin
            r = v; g = p; b = q;
         end
      endcase
      rgb.red   = r[FIELD_W-1:0];
      rgb.green = g[FIELD_W-1:0];
      rgb.blue  = b[FIELD_W-1:0];
      return rgb;
   endfunction

   // Print one line per mismatch and count it
   task automatic report_mismatch(string what);
      $display("mismatch at result %0d: %s", rsp_index, what);
      fail_count++;
   endtask

   // Queue a prediction per accepted input word, check each accepted output word
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            rgb_expected.push_back(predict_rgb(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (rgb_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected word %h", rsp_word));
            end else begin
               want = rgb_expected.pop_front();
               if (rsp_word.red !== want.red)
                  report_mismatch($sformatf("red expected %h got %h",
                                            want.red, rsp_word.red));
               if (rsp_word.green !== want.green)
                  report_mismatch($sformatf("green expected %h got %h",
                                            want.green, rsp_word.green));
               if (rsp_word.blue !== want.blue)
                  report_mismatch($sformatf("blue expected %h got %h",
                                            want.blue, rsp_word.blue));
            end
            rsp_index++;
         end
      end
      pending <= rgb_expected.size();
   end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import hsvrgb_pkg::*;

   localparam int RANDOM_WORDS   = 1500;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 16;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;
   int           fail_count;
   int           pending;
   int           idle_count;
   logic         source_quiet;

   hsv_to_rgb_converter_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   hsv_rgb_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Mostly short gaps, a few long ones
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      else if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Component levels: extremes and single bits now and then, else uniform
   function automatic logic [FIELD_W-1:0] pick_level();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 16'h0001;
         3: return 16'h8000;
         4: return 16'hFFFE;
         default: return FIELD_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // Hue near a sector edge in a quarter of the words
   function automatic logic [FIELD_W-1:0] pick_hue();
      logic [FIELD_W-1:0] edges[6];
      logic [FIELD_W-1:0] base;
      edges = '{16'd0, 16'd10923, 16'd21846, 16'd32768, 16'd43691, 16'd54614};
      if ($urandom_range(0, 3) != 0)
         return pick_level();
      base = edges[$urandom_range(0, 5)];
      return base + FIELD_W'($urandom_range(0, 4)) - 16'd2;
   endfunction

   // Present one word after an optional gap and hold it until accepted
   task automatic push_color(req_word_type color);
      int gap;
      gap = source_quiet ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= color;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic req_word_type make_color(int h, int s, int v);
      req_word_type color;
      color.hue        = FIELD_W'(h);
      color.saturation = FIELD_W'(s);
      color.brightness = FIELD_W'(v);
      return color;
   endfunction

   // Stall the result side in bursts, with long free stretches now and then
   initial begin
      int free_cycles;
      int stall_cycles;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 7) == 0)
            free_cycles = $urandom_range(50, 150);
         else
            free_cycles = $urandom_range(1, 8);
         stall_cycles = gap_length();
         if (stall_cycles == 0)
            stall_cycles = 1;
         repeat (free_cycles) @(posedge clock);
         rsp_stall <= 1'b1;
         repeat (stall_cycles) @(posedge clock);
         rsp_stall <= 1'b0;
      end
   end

   // Abort when no word moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("hsv_to_rgb_converter_core test failed");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   initial begin
      req_word_type directed[$];
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_word     = '0;
      source_quiet = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Extremes, every sector edge, full saturation and zero brightness
      directed.push_back(make_color(0, 0, 0));
      directed.push_back(make_color(65535, 65535, 65535));
      directed.push_back(make_color(0, 65535, 65535));
      directed.push_back(make_color(65535, 0, 65535));
      directed.push_back(make_color(10922, 65535, 65535));
      directed.push_back(make_color(10923, 65535, 65535));
      directed.push_back(make_color(21845, 65535, 65535));
      directed.push_back(make_color(21846, 65535, 65535));
      directed.push_back(make_color(32767, 65535, 65535));
      directed.push_back(make_color(32768, 65535, 65535));
      directed.push_back(make_color(43690, 65535, 65535));
      directed.push_back(make_color(43691, 65535, 65535));
      directed.push_back(make_color(54613, 65535, 65535));
      directed.push_back(make_color(54614, 65535, 65535));
      directed.push_back(make_color(5461, 32768, 65535));
      directed.push_back(make_color(27306, 65535, 0));
      directed.push_back(make_color(49151, 1, 65534));
      directed.push_back(make_color(16384, 40000, 50000));
      directed.push_back(make_color(60000, 65535, 1));
      foreach (directed[i])
         push_color(directed[i]);

      // Random words, with back-to-back stretches every couple hundred
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i % 200 == 0)
            source_quiet = ($urandom_range(0, 2) == 0);
         push_color(make_color(pick_hue(), pick_level(), pick_level()));
      end
      req_valid <= 1'b0;

      // Drain, then let the pipeline settle
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("hsv_to_rgb_converter_core test passed");
      else
         $display("hsv_to_rgb_converter_core test failed");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsvrgb_sector_split.sv
hw/rtl/hsvrgb_products.sv
hw/rtl/hsvrgb_route.sv
hw/rtl/hsv_to_rgb_converter_core.sv
sim/hsv_rgb_checker.sv
sim/testbench.sv
